### rtl/tfsg_pkg.sv
// Shared types and constants for the thermal fan speed governor.
`default_nettype none

package tfsg_pkg;

    // Fan speed limits, percent
    localparam int SPEED_W = 7;
    localparam logic [SPEED_W-1:0] SPEED_MIN = 7'd35;
    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

    // Curve knees and tops, 1/16 deg C
    localparam int ASIC_KNEE = 49 * 16;
    localparam int ASIC_TOP  = 90 * 16;
    localparam int GDDR_KNEE = 43 * 16;
    localparam int GDDR_TOP  = 82 * 16;

    // Distance above the knee fits this many bits inside the quadratic span
    localparam int DIST_W = 10;

    // Curve coefficients as fractions of COEFF_DEN
    localparam longint unsigned ASIC_COEFF_NUM = 3867;
    localparam longint unsigned GDDR_COEFF_NUM = 4274;
    localparam longint unsigned COEFF_DEN      = 100000;

    // Force value that releases the fan besides zero
    localparam logic [31:0] UNFORCE_ALL_ONES = 32'hFFFF_FFFF;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ALPHA   = 2'd0,
        CFG_GDDR_EN = 2'd1,
        CFG_CTRL_EN = 2'd2
    } cfg_idx_t;

    // Configuration register file
    typedef struct packed {
        logic [6:0] alpha;
        logic       gddr_en;
        logic       ctrl_en;
    } cfg_t;

    // Command classes produced by the front end
    localparam int CMD_W = 2;
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK    = 2'd0,
        CMD_LOCK    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_REJECT  = 2'd3
    } cmd_t;

    // Back end sequencer states
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL    = 7'b0000010,
        ST_SUM    = 7'b0000100,
        ST_DIV    = 7'b0001000,
        ST_SQR    = 7'b0010000,
        ST_SCALE  = 7'b0100000,
        ST_RESULT = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

### rtl/tfsg_queue.sv
// Two-entry command queue between the front and back ends.
`default_nettype none

module tfsg_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

### rtl/tfsg_front.sv
// Front end: takes input transfers, classifies them and queues commands.
`default_nettype none

module tfsg_front #(
    parameter int TEMP_WIDTH = 13
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         ctrl_en,
    // input transfer
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_kind,
    input  wire logic signed [TEMP_WIDTH-1:0] s_asic,
    input  wire logic signed [TEMP_WIDTH-1:0] s_gddr,
    input  wire logic [31:0]                  s_raw_speed,
    // command to the back end
    output logic                              q_valid,
    input  wire logic                         q_ready,
    output tfsg_pkg::cmd_t                    q_code,
    output logic [tfsg_pkg::SPEED_W-1:0]      q_speed,
    output logic signed [TEMP_WIDTH-1:0]      q_asic,
    output logic signed [TEMP_WIDTH-1:0]      q_gddr
);

    localparam int EW = tfsg_pkg::CMD_W + tfsg_pkg::SPEED_W + 2 * TEMP_WIDTH;

    tfsg_pkg::cmd_t                 code;
    logic [tfsg_pkg::SPEED_W-1:0]   speed_sat;
    logic [EW-1:0]                  entry_in;
    logic [EW-1:0]                  entry_out;

    // Classify: tick, lock, release, or reject when control is off
    always_comb begin
        if (!s_kind) begin
            code = tfsg_pkg::CMD_TICK;
        end else if (!ctrl_en) begin
            code = tfsg_pkg::CMD_REJECT;
        end else if (s_raw_speed == 32'd0 || s_raw_speed == tfsg_pkg::UNFORCE_ALL_ONES) begin
            code = tfsg_pkg::CMD_RELEASE;
        end else begin
            code = tfsg_pkg::CMD_LOCK;
        end
    end

    // Saturate the requested speed to 100 percent
    assign speed_sat = (s_raw_speed > 32'(tfsg_pkg::SPEED_MAX)) ? tfsg_pkg::SPEED_MAX
                                                               : s_raw_speed[tfsg_pkg::SPEED_W-1:0];

    assign entry_in = {code, speed_sat, s_gddr, s_asic};

    tfsg_queue #(
        .WIDTH (EW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (entry_in),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (entry_out)
    );

    assign q_code  = tfsg_pkg::cmd_t'(entry_out[EW-1 -: tfsg_pkg::CMD_W]);
    assign q_speed = entry_out[2*TEMP_WIDTH +: tfsg_pkg::SPEED_W];
    assign q_gddr  = entry_out[TEMP_WIDTH +: TEMP_WIDTH];
    assign q_asic  = entry_out[0 +: TEMP_WIDTH];

endmodule

`default_nettype wire

### rtl/tfsg_back.sv
// Back end: averaging and curve sequencer, governor state and result register.
`default_nettype none

module tfsg_back #(
    parameter int TEMP_WIDTH      = 13,
    parameter int COEFF_FRAC_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire tfsg_pkg::cfg_t               cfg,
    // command from the queue
    input  wire logic                         q_valid,
    output logic                              q_ready,
    input  wire tfsg_pkg::cmd_t               q_code,
    input  wire logic [tfsg_pkg::SPEED_W-1:0] q_speed,
    input  wire logic signed [TEMP_WIDTH-1:0] q_asic,
    input  wire logic signed [TEMP_WIDTH-1:0] q_gddr,
    // result transfer
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [tfsg_pkg::SPEED_W-1:0]      m_speed,
    output logic                              m_forced,
    output logic                              m_status
);

    localparam int TW    = TEMP_WIDTH;
    localparam int F     = COEFF_FRAC_BITS;
    // Offset numerator so the floor division sees a non-negative value
    localparam int AW    = TW + 7;
    localparam int MW    = AW + 1;
    localparam int SH    = AW + 7;
    localparam longint unsigned RECIP_L = ((64'd1 << SH) + 64'd99) / 64'd100;
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
    localparam logic signed [TW+9:0] OFFSET = (TW+10)'(100 * (2 ** (TW - 1)));
    // Coefficients are below 1/16, so F-4 bits hold them
    localparam int CW    = F - 4;
    localparam longint unsigned ACOEF_L = (tfsg_pkg::ASIC_COEFF_NUM << F) / tfsg_pkg::COEFF_DEN;
    localparam longint unsigned GCOEF_L = (tfsg_pkg::GDDR_COEFF_NUM << F) / tfsg_pkg::COEFF_DEN;
    localparam logic [CW-1:0] ASIC_COEFF = CW'(ACOEF_L);
    localparam logic [CW-1:0] GDDR_COEFF = CW'(GCOEF_L);
    localparam int DW    = tfsg_pkg::DIST_W;
    localparam int QW    = 2 * DW;
    localparam int SCW   = QW + CW;

    tfsg_pkg::state_t state_reg, state_next;
    logic                          ch_reg;
    logic signed [TW-1:0]          asic_avg_reg;
    logic signed [TW-1:0]          gddr_avg_reg;
    logic                          primed_reg;
    logic                          force_reg;
    logic signed [TW-1:0]          smp_asic_reg;
    logic signed [TW-1:0]          smp_gddr_reg;
    logic signed [TW+7:0]          prod_reg;
    logic [AW-1:0]                 acc_reg;
    logic [QW-1:0]                 dd_reg;
    logic                          below_reg;
    logic                          above_reg;
    logic [tfsg_pkg::SPEED_W-1:0]  spd_asic_reg;
    logic [tfsg_pkg::SPEED_W-1:0]  spd_gddr_reg;
    logic                          out_valid_reg;
    logic [tfsg_pkg::SPEED_W-1:0]  out_speed_reg;
    logic                          out_forced_reg;
    logic                          out_status_reg;

    logic [6:0]                    alpha_eff;
    logic [6:0]                    alpha_comp;
    logic signed [TW-1:0]          smp_sel;
    logic signed [TW-1:0]          avg_sel;
    logic signed [TW+7:0]          mul_new;
    logic signed [TW+7:0]          mul_old;
    logic signed [TW+9:0]          acc_sum;
    logic [AW+MW-1:0]              div_full;
    logic [TW-1:0]                 quot;
    logic signed [TW-1:0]          avg_new;
    int                            t_ext;
    int                            knee_sel;
    int                            top_sel;
    int                            dist_full;
    logic [DW-1:0]                 delta;
    logic [QW-1:0]                 dist_sq;
    logic [CW-1:0]                 coeff_sel;
    logic [SCW-1:0]                scaled;
    logic [7:0]                    curve_sum;
    logic [tfsg_pkg::SPEED_W-1:0]  curve_spd;
    logic [tfsg_pkg::SPEED_W-1:0]  tick_spd;
    logic                          out_free;
    logic                          pop;
    logic                          pop_tick_run;
    logic                          load_cmd;
    logic                          load_tick;

    // Handshake with the queue and the result register
    assign out_free     = !out_valid_reg || m_ready;
    assign q_ready      = (state_reg == tfsg_pkg::ST_IDLE) && out_free;
    assign pop          = q_valid && q_ready;
    assign pop_tick_run = pop && (q_code == tfsg_pkg::CMD_TICK) && !force_reg && primed_reg;
    assign load_cmd     = pop && (q_code != tfsg_pkg::CMD_TICK);
    assign load_tick    = (state_reg == tfsg_pkg::ST_RESULT) && out_free;

    // Channel select: 0 is the chip, 1 the memory
    assign smp_sel   = ch_reg ? smp_gddr_reg : smp_asic_reg;
    assign avg_sel   = ch_reg ? gddr_avg_reg : asic_avg_reg;
    assign knee_sel  = ch_reg ? tfsg_pkg::GDDR_KNEE : tfsg_pkg::ASIC_KNEE;
    assign top_sel   = ch_reg ? tfsg_pkg::GDDR_TOP : tfsg_pkg::ASIC_TOP;
    assign coeff_sel = ch_reg ? GDDR_COEFF : ASIC_COEFF;

    // Exponential average: weights, numerator, floor divide by 100
    assign alpha_eff  = (cfg.alpha > tfsg_pkg::SPEED_MAX) ? tfsg_pkg::SPEED_MAX : cfg.alpha;
    assign alpha_comp = tfsg_pkg::SPEED_MAX - alpha_eff;
    assign mul_new    = (TW+8)'($signed({1'b0, alpha_eff})) * (TW+8)'(smp_sel);
    assign mul_old    = (TW+8)'($signed({1'b0, alpha_comp})) * (TW+8)'(avg_sel);
    assign acc_sum    = (TW+10)'(prod_reg) + (TW+10)'(mul_old) + OFFSET;
    assign div_full   = (AW+MW)'(acc_reg) * (AW+MW)'(RECIP);
    assign quot       = div_full[SH +: TW];
    // Removing the offset of 2^(TW-1) flips the top bit
    assign avg_new    = {~quot[TW-1], quot[TW-2:0]};

    // Curve: distance above the knee and its square
    assign t_ext     = int'(avg_sel);
    assign dist_full = t_ext - knee_sel;
    assign delta     = dist_full[DW-1:0];
    assign dist_sq   = QW'(delta) * QW'(delta);

    // Curve: scale by the coefficient, add the floor speed, clamp
    assign scaled    = SCW'(dd_reg) * SCW'(coeff_sel);
    assign curve_sum = scaled[F+8 +: 8] + 8'(tfsg_pkg::SPEED_MIN);
    always_comb begin
        if (below_reg) begin
            curve_spd = tfsg_pkg::SPEED_MIN;
        end else if (above_reg || curve_sum > 8'(tfsg_pkg::SPEED_MAX)) begin
            curve_spd = tfsg_pkg::SPEED_MAX;
        end else begin
            curve_spd = curve_sum[tfsg_pkg::SPEED_W-1:0];
        end
    end

    assign tick_spd = (spd_asic_reg > spd_gddr_reg) ? spd_asic_reg : spd_gddr_reg;

    // Sequencer: five steps per channel, chip then memory
    always_comb begin
        case (state_reg)
            tfsg_pkg::ST_IDLE: begin
                state_next = pop_tick_run ? tfsg_pkg::ST_MUL : tfsg_pkg::ST_IDLE;
            end
            tfsg_pkg::ST_MUL:   state_next = tfsg_pkg::ST_SUM;
            tfsg_pkg::ST_SUM:   state_next = tfsg_pkg::ST_DIV;
            tfsg_pkg::ST_DIV:   state_next = tfsg_pkg::ST_SQR;
            tfsg_pkg::ST_SQR:   state_next = tfsg_pkg::ST_SCALE;
            tfsg_pkg::ST_SCALE: begin
                state_next = ch_reg ? tfsg_pkg::ST_RESULT : tfsg_pkg::ST_MUL;
            end
            tfsg_pkg::ST_RESULT: begin
                state_next = out_free ? tfsg_pkg::ST_IDLE : tfsg_pkg::ST_RESULT;
            end
            default:            state_next = tfsg_pkg::ST_IDLE;
        endcase
    end

    // Control and governor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tfsg_pkg::ST_IDLE;
            ch_reg        <= 1'b0;
            asic_avg_reg  <= '0;
            gddr_avg_reg  <= '0;
            primed_reg    <= 1'b0;
            force_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (state_reg == tfsg_pkg::ST_IDLE) begin
                ch_reg <= 1'b0;
            end else if (state_reg == tfsg_pkg::ST_SCALE) begin
                ch_reg <= 1'b1;
            end

            // First tick only loads the chip average
            if (pop && q_code == tfsg_pkg::CMD_TICK && !force_reg && !primed_reg) begin
                asic_avg_reg <= q_asic;
                primed_reg   <= 1'b1;
            end

            if (state_reg == tfsg_pkg::ST_DIV) begin
                if (!ch_reg) begin
                    asic_avg_reg <= avg_new;
                end else begin
                    gddr_avg_reg <= cfg.gddr_en ? avg_new : '0;
                end
            end

            if (pop && q_code == tfsg_pkg::CMD_LOCK) begin
                force_reg <= 1'b1;
            end else if (pop && q_code == tfsg_pkg::CMD_RELEASE) begin
                force_reg <= 1'b0;
            end

            if (load_cmd || load_tick) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (pop) begin
            smp_asic_reg <= q_asic;
            smp_gddr_reg <= q_gddr;
        end
        if (state_reg == tfsg_pkg::ST_MUL) begin
            prod_reg <= mul_new;
        end
        if (state_reg == tfsg_pkg::ST_SUM) begin
            acc_reg <= acc_sum[AW-1:0];
        end
        if (state_reg == tfsg_pkg::ST_SQR) begin
            dd_reg    <= dist_sq;
            below_reg <= (t_ext < knee_sel);
            above_reg <= (t_ext >= top_sel);
        end
        if (state_reg == tfsg_pkg::ST_SCALE) begin
            if (ch_reg) begin
                spd_gddr_reg <= curve_spd;
            end else begin
                spd_asic_reg <= curve_spd;
            end
        end

        // Result register
        if (load_cmd) begin
            out_speed_reg  <= (q_code == tfsg_pkg::CMD_LOCK) ? q_speed : '0;
            out_forced_reg <= (q_code == tfsg_pkg::CMD_REJECT) ? force_reg
                                                               : (q_code == tfsg_pkg::CMD_LOCK);
            out_status_reg <= (q_code == tfsg_pkg::CMD_REJECT);
        end else if (load_tick) begin
            out_speed_reg  <= tick_spd;
            out_forced_reg <= 1'b0;
            out_status_reg <= 1'b0;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_speed  = out_speed_reg;
    assign m_forced = out_forced_reg;
    assign m_status = out_status_reg;

endmodule

`default_nettype wire

### rtl/thermal_fan_speed_governor_unit.sv
// Top level of the thermal fan speed governor: ports, registers, front and back.
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_       | in        | tdata: asic_temp, gddr_temp, forced_speed; tuser: kind
//  m_       | out       | tdata: fan drive percent; tuser: forced, status
//  cfg_     | in        | write only: alpha_percent, gddr_enable, control_enable
//
// A force item leaves the queue and loads the result register when the back end pops it.
// A primed, unforced tick holds the back end for the pop, five steps per channel
// (weight, numerator, divide by 100, square, scale), chip then memory, and the
// result load, which waits until the result register is free.
// A waiting result holds the back end; the two-entry queue then fills and stalls input.
// Reset restores the register defaults and clears averages, priming and force flags.
`default_nettype none

module thermal_fan_speed_governor_unit #(
    parameter int TEMP_WIDTH      = 13,
    parameter int COEFF_FRAC_BITS = 16
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input channel
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [((2*TEMP_WIDTH+39)/8)*8-1:0] s_tdata, // asic_temp, gddr_temp, forced_speed
    input  wire logic                  s_tuser,   // kind
    // result channel
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // fan drive percent
    output logic [1:0]                 m_tuser,   // forced, status
    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [6:0]            cfg_wdata
);

    localparam int TW = TEMP_WIDTH;

    tfsg_pkg::cfg_t                cfg_reg;
    tfsg_pkg::cmd_t                q_code;
    logic                          q_valid;
    logic                          q_ready;
    logic [tfsg_pkg::SPEED_W-1:0]  q_speed;
    logic signed [TW-1:0]          q_asic;
    logic signed [TW-1:0]          q_gddr;
    logic [tfsg_pkg::SPEED_W-1:0]  m_speed;
    logic                          m_forced;
    logic                          m_status;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha   <= 7'd50;
            cfg_reg.gddr_en <= 1'b1;
            cfg_reg.ctrl_en <= 1'b1;
        end else if (cfg_wr_en) begin
            case (tfsg_pkg::cfg_idx_t'(cfg_index))
                tfsg_pkg::CFG_ALPHA:   cfg_reg.alpha   <= cfg_wdata;
                tfsg_pkg::CFG_GDDR_EN: cfg_reg.gddr_en <= cfg_wdata[0];
                tfsg_pkg::CFG_CTRL_EN: cfg_reg.ctrl_en <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    tfsg_front #(
        .TEMP_WIDTH (TW)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl_en     (cfg_reg.ctrl_en),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_kind      (s_tuser),
        .s_asic      (s_tdata[0 +: TW]),
        .s_gddr      (s_tdata[TW +: TW]),
        .s_raw_speed (s_tdata[2*TW +: 32]),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_code      (q_code),
        .q_speed     (q_speed),
        .q_asic      (q_asic),
        .q_gddr      (q_gddr)
    );

    tfsg_back #(
        .TEMP_WIDTH      (TW),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_code   (q_code),
        .q_speed  (q_speed),
        .q_asic   (q_asic),
        .q_gddr   (q_gddr),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_speed  (m_speed),
        .m_forced (m_forced),
        .m_status (m_status)
    );

    assign m_tdata = {1'b0, m_speed};
    assign m_tuser = {m_status, m_forced};

endmodule

`default_nettype wire

### verif/thermal_fan_speed_governor_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench: directed and random stimulus against a built-in governor predictor.
module thermal_fan_speed_governor_unit_tb;

    localparam int   TEMP_W          = 13;
    localparam int   COEFF_F         = 16;
    localparam int   TDATA_W         = ((2*TEMP_W+32+7)/8)*8;
    localparam int   SPD_W           = tfsg_pkg::SPEED_W;
    localparam logic KIND_TICK       = 1'b0;
    localparam logic KIND_FORCE      = 1'b1;
    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;
    localparam int   SETTLE_CYCLES   = 40;
    localparam int   HOLD_CYCLES     = 200;
    localparam int   WATCHDOG_LIMIT  = 4000;
    localparam int   PHASE_ITEMS     = 200;

    typedef struct {
        logic                     kind;
        logic signed [TEMP_W-1:0] asic;
        logic signed [TEMP_W-1:0] gddr;
        logic [31:0]              speed;
    } gov_item_t;

    typedef struct {
        logic [SPD_W-1:0] duty;
        logic             forced;
        logic             status;
    } fan_result_t;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata   = '0;  // asic_temp, gddr_temp, forced_speed, zero pad
    logic               s_tuser   = 1'b0;  // kind
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [7:0]         m_tdata;  // fan drive percent, zero pad
    logic [1:0]         m_tuser;  // forced, status
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = tfsg_pkg::CFG_ALPHA;
    logic [6:0]         cfg_wdata = '0;

    // Predictor copy of registers and state
    logic [6:0] reg_alpha   = 7'd50;
    logic       reg_gddr_en = 1'b1;
    logic       reg_ctrl_en = 1'b1;
    int         avg_asic    = 0;
    int         avg_gddr    = 0;
    bit         is_primed   = 1'b0;
    bit         is_forced   = 1'b0;

    fan_result_t pending_results[$];
    int error_count   = 0;
    bit tx_idle_en    = 1'b1;
    bit rx_idle_en    = 1'b1;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    thermal_fan_speed_governor_unit #(
        .TEMP_WIDTH      (TEMP_W),
        .COEFF_FRAC_BITS (COEFF_F)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #6 aclk = ~aclk;

    // Exponential average, floor toward minus infinity
    function automatic int ewma(int sample, int avg);
        longint a, num, q;
        a   = (reg_alpha > 7'd100) ? 100 : longint'(reg_alpha);
        num = a * sample + (100 - a) * avg;
        q   = num / 100;
        if (num % 100 != 0 && num < 0) q = q - 1;
        return int'(q);
    endfunction

    // Piecewise quadratic speed curve with truncated Q0.F coefficient
    function automatic logic [SPD_W-1:0] speed_curve(int t, int knee, int top,
                                                     longint unsigned num);
        longint unsigned coeff, d, s;
        if (t < knee) return tfsg_pkg::SPEED_MIN;
        if (t >= top) return tfsg_pkg::SPEED_MAX;
        coeff = (num << COEFF_F) / tfsg_pkg::COEFF_DEN;
        d     = longint'(t - knee);
        s     = ((coeff * d * d) >> (COEFF_F + 8)) + tfsg_pkg::SPEED_MIN;
        if (s > tfsg_pkg::SPEED_MAX) s = tfsg_pkg::SPEED_MAX;
        return s[SPD_W-1:0];
    endfunction

    // Advance the governor state by one accepted item
    function automatic void governor_predict(input gov_item_t it, output bit has_res,
                                             output fan_result_t res);
        logic [SPD_W-1:0] sp_asic, sp_gddr;
        has_res    = 1'b0;
        res.duty   = '0;
        res.forced = 1'b0;
        res.status = STATUS_OK;
        if (it.kind == KIND_TICK) begin
            if (is_forced) return;
            if (!is_primed) begin
                avg_asic  = it.asic;
                is_primed = 1'b1;
                return;
            end
            avg_asic = ewma(it.asic, avg_asic);
            avg_gddr = reg_gddr_en ? ewma(it.gddr, avg_gddr) : 0;
            sp_asic  = speed_curve(avg_asic, tfsg_pkg::ASIC_KNEE, tfsg_pkg::ASIC_TOP,
                                   tfsg_pkg::ASIC_COEFF_NUM);
            sp_gddr  = speed_curve(avg_gddr, tfsg_pkg::GDDR_KNEE, tfsg_pkg::GDDR_TOP,
                                   tfsg_pkg::GDDR_COEFF_NUM);
            res.duty = (sp_asic > sp_gddr) ? sp_asic : sp_gddr;
        end else if (!reg_ctrl_en) begin
            res.forced = is_forced;
            res.status = STATUS_REJECTED;
        end else if (it.speed == 32'd0 || it.speed == tfsg_pkg::UNFORCE_ALL_ONES) begin
            is_forced = 1'b0;
        end else begin
            is_forced  = 1'b1;
            res.duty   = (it.speed > 32'd100) ? tfsg_pkg::SPEED_MAX : it.speed[SPD_W-1:0];
            res.forced = 1'b1;
        end
        has_res = 1'b1;
    endfunction

    function automatic gov_item_t tick_item(int asic, int gddr);
        gov_item_t it;
        it.kind  = KIND_TICK;
        it.asic  = TEMP_W'(asic);
        it.gddr  = TEMP_W'(gddr);
        it.speed = $urandom();
        return it;
    endfunction

    function automatic gov_item_t force_item(logic [31:0] speed);
        gov_item_t it;
        it.kind  = KIND_FORCE;
        it.asic  = TEMP_W'($urandom());
        it.gddr  = TEMP_W'($urandom());
        it.speed = speed;
        return it;
    endfunction

    // Mostly ticks around the curve span, some full range, releases and locks
    function automatic gov_item_t random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return tick_item($urandom_range(1650, 550), $urandom_range(1500, 450));
        if (pick < 82)
            return tick_item(int'($urandom_range(8191)) - 4096,
                             int'($urandom_range(8191)) - 4096);
        if (pick < 94)
            return force_item($urandom_range(1) ? 32'd0 : tfsg_pkg::UNFORCE_ALL_ONES);
        if (pick < 97)
            return force_item($urandom_range(127));
        return force_item($urandom());
    endfunction

    // One input transfer after optional random idle gaps; valid stays high so back-to-back items need no gap
    task automatic send_item(input gov_item_t it);
        bit          has_res;
        fan_result_t res;
        while (tx_idle_en && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.kind;
        s_tdata  <= {{(TDATA_W-2*TEMP_W-32){1'b0}}, it.speed, it.gddr, it.asic};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        governor_predict(it, has_res, res);
        if (has_res) pending_results.push_back(res);
    endtask

    // Stop offering, wait for every result, then let silent ticks finish
    task automatic wait_until_settled();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input tfsg_pkg::cfg_idx_t idx, input logic [6:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            tfsg_pkg::CFG_ALPHA:   reg_alpha   = value;
            tfsg_pkg::CFG_GDDR_EN: reg_gddr_en = value[0];
            tfsg_pkg::CFG_CTRL_EN: reg_ctrl_en = value[0];
            default: ;
        endcase
    endtask

    // Force before any tick, tick ignored while forced, then priming
    task automatic test_priming_under_force();
        send_item(force_item(32'd50));
        send_item(tick_item(1200, 1000));
        send_item(force_item(32'd0));
        send_item(tick_item(1000, 900));
        send_item(tick_item(1100, 1000));
        wait_until_settled();
    endtask

    // Averages follow samples exactly at alpha 100: probe knees, tops, extremes
    task automatic test_curve_edges();
        write_register(tfsg_pkg::CFG_ALPHA, 7'd100);
        send_item(tick_item(-4096, -4096));
        send_item(tick_item(4095, 4095));
        send_item(tick_item(tfsg_pkg::ASIC_KNEE - 1, -4096));
        send_item(tick_item(tfsg_pkg::ASIC_KNEE + 1, -4096));
        send_item(tick_item(tfsg_pkg::ASIC_TOP - 1, -4096));
        send_item(tick_item(tfsg_pkg::ASIC_TOP, -4096));
        send_item(tick_item(-4096, tfsg_pkg::GDDR_KNEE - 1));
        send_item(tick_item(-4096, tfsg_pkg::GDDR_KNEE + 1));
        send_item(tick_item(-4096, tfsg_pkg::GDDR_TOP - 1));
        send_item(tick_item(-4096, tfsg_pkg::GDDR_TOP));
        wait_until_settled();
    endtask

    // Lock values with saturation, both release codes
    task automatic test_force_values();
        send_item(force_item(32'd1));
        send_item(force_item(32'd100));
        send_item(force_item(32'd101));
        send_item(force_item(32'h8000_0000));
        send_item(force_item(32'hFFFF_FFFE));
        send_item(tick_item(1300, 1200));
        send_item(force_item(tfsg_pkg::UNFORCE_ALL_ONES));
        send_item(force_item(32'd0));
        send_item(tick_item(1300, 1200));
        wait_until_settled();
    endtask

    // Rejected forces report the current force flag and change nothing
    task automatic test_control_disable();
        write_register(tfsg_pkg::CFG_CTRL_EN, 7'd0);
        send_item(force_item(32'd60));
        send_item(tick_item(1250, 1100));
        wait_until_settled();
        write_register(tfsg_pkg::CFG_CTRL_EN, 7'd1);
        send_item(force_item(32'd60));
        wait_until_settled();
        write_register(tfsg_pkg::CFG_CTRL_EN, 7'd0);
        send_item(force_item(32'd0));
        send_item(force_item(32'd70));
        wait_until_settled();
        write_register(tfsg_pkg::CFG_CTRL_EN, 7'd1);
        send_item(force_item(tfsg_pkg::UNFORCE_ALL_ONES));
        wait_until_settled();
    endtask

    // Memory average pinned at zero while disabled, then resumes from zero
    task automatic test_gddr_disable();
        write_register(tfsg_pkg::CFG_ALPHA, 7'd50);
        write_register(tfsg_pkg::CFG_GDDR_EN, 7'd0);
        send_item(tick_item(500, 4095));
        send_item(tick_item(500, 1300));
        wait_until_settled();
        write_register(tfsg_pkg::CFG_GDDR_EN, 7'd1);
        send_item(tick_item(500, 1300));
        wait_until_settled();
    endtask

    // Receiver holds off while the sender keeps offering, then sender drains
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        send_item(force_item(32'd0));
        hold_requests = hold_requests + 1;
        repeat (30) send_item(tick_item($urandom_range(1650, 550), $urandom_range(1500, 450)));
        wait_until_settled();
        tx_idle_en = 1'b1;
    endtask

    task automatic run_phase(input logic [6:0] alpha, input bit gddr_en, input bit ctrl_en,
                             input bit idle_en);
        write_register(tfsg_pkg::CFG_CTRL_EN, 7'd1);
        send_item(force_item(32'd0));
        wait_until_settled();
        write_register(tfsg_pkg::CFG_ALPHA, alpha);
        write_register(tfsg_pkg::CFG_GDDR_EN, {6'($urandom_range(63)), gddr_en});
        write_register(tfsg_pkg::CFG_CTRL_EN, {6'($urandom_range(63)), ctrl_en});
        tx_idle_en = idle_en;
        rx_idle_en = idle_en;
        repeat (PHASE_ITEMS) send_item(random_item());
        wait_until_settled();
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_random_settings();
        run_phase(7'd50, 1'b1, 1'b1, 1'b1);
        run_phase(7'd0, 1'b1, 1'b1, 1'b1);
        run_phase(7'd127, 1'b0, 1'b1, 1'b0);
        run_phase(7'd100, 1'b1, 1'b1, 1'b1);
        run_phase(7'($urandom_range(127)), 1'($urandom_range(1)), 1'b0, 1'b1);
        run_phase(7'($urandom_range(100)), 1'b1, 1'($urandom_range(1)), 1'b1);
    endtask

    // Result checking and receiver ready
    always @(posedge aclk) begin
        fan_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.duty   = m_tdata[SPD_W-1:0];
            got.forced = m_tuser[0];
            got.status = m_tuser[1];
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %0d %0b %0b",
                         $time, got.duty, got.forced, got.status);
            end else begin
                want = pending_results.pop_front();
                if (got.duty !== want.duty) begin
                    error_count++;
                    $display("%0t: speed expected %0d actual %0d",
                             $time, want.duty, got.duty);
                end
                if (got.forced !== want.forced) begin
                    error_count++;
                    $display("%0t: forced expected %0b actual %0b",
                             $time, want.forced, got.forced);
                end
                if (got.status !== want.status) begin
                    error_count++;
                    $display("%0t: status expected %0b actual %0b",
                             $time, want.status, got.status);
                end
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= !rx_idle_en || ($urandom_range(99) >= 27);
        end
    end

    // Watchdog: cycles without any transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[thermal_fan_speed_governor_unit] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_priming_under_force();
        test_curve_edges();
        test_force_values();
        test_control_disable();
        test_gddr_disable();
        test_backpressure();
        test_random_settings();
        wait_until_settled();
        if (error_count == 0)
            $display("[thermal_fan_speed_governor_unit] OK");
        else
            $display("[thermal_fan_speed_governor_unit] ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/tfsg_pkg.sv
rtl/tfsg_queue.sv
rtl/tfsg_front.sv
rtl/tfsg_back.sv
rtl/thermal_fan_speed_governor_unit.sv
verif/thermal_fan_speed_governor_unit_tb.sv
